FILE: hw/rtl/pcsc_pkg.sv
package pcsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint FULL = 255 * ONE;
  localparam longint MID = FULL / 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b1;

  typedef enum logic [2:0] {
    SP_RGB    = 3'd0,
    SP_HSL    = 3'd1,
    SP_HSV    = 3'd2,
    SP_YCC601 = 3'd3,
    SP_YCC709 = 3'd4,
    SP_YCOCG  = 3'd5,
    SP_CMY    = 3'd6
  } space_t;

  // luma weights
  localparam longint KR_601 = (299 * ONE + 500) / 1000;
  localparam longint KG_601 = (587 * ONE + 500) / 1000;
  localparam longint KB_601 = (114 * ONE + 500) / 1000;
  localparam longint KR_709 = (2126 * ONE + 5000) / 10000;
  localparam longint KG_709 = (7152 * ONE + 5000) / 10000;
  localparam longint KB_709 = (722 * ONE + 5000) / 10000;

  localparam longint CRR_601 = 2 * ONE - 2 * KR_601;
  localparam longint CBB_601 = 2 * ONE - 2 * KB_601;
  localparam longint CRR_709 = 2 * ONE - 2 * KR_709;
  localparam longint CBB_709 = 2 * ONE - 2 * KB_709;

  localparam longint KGB_601 = KB_601 * CBB_601 / KG_601;
  localparam longint KGR_601 = KR_601 * CRR_601 / KG_601;
  localparam longint KGB_709 = KB_709 * CBB_709 / KG_709;
  localparam longint KGR_709 = KR_709 * CRR_709 / KG_709;

  // reciprocals for the chroma divide, scaled by 2^(FRAC_BITS+24)
  localparam int INV_SHIFT = 24;
  localparam longint INV_CBB_601 = (longint'(1) << (FRAC_BITS + INV_SHIFT)) / CBB_601;
  localparam longint INV_CRR_601 = (longint'(1) << (FRAC_BITS + INV_SHIFT)) / CRR_601;
  localparam longint INV_CBB_709 = (longint'(1) << (FRAC_BITS + INV_SHIFT)) / CBB_709;
  localparam longint INV_CRR_709 = (longint'(1) << (FRAC_BITS + INV_SHIFT)) / CRR_709;

  typedef struct packed {
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
  } pixel_t;

  typedef struct packed {
    logic [7:0] res_first;
    logic [7:0] res_second;
    logic [7:0] res_third;
  } result_t;

  function automatic logic [7:0] to_byte(input logic signed [47:0] v);
    if (v < 0) return 8'h00;
    if (v > 48'(FULL)) return 8'hFF;
    return v[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // fixed product rescale, truncating toward zero
  function automatic logic signed [47:0] trunc_fx(input logic signed [47:0] p);
    if (p < 0) return -((-p) >>> FRAC_BITS);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [7:0] scale255(input logic [17:0] v);
    logic [25:0] t;
    t = 26'(v) * 26'd255;
    if (t > 26'(FULL)) return 8'hFF;
    return t[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

FILE: hw/rtl/pixel_color_space_converter.sv
// throughput: one pixel per cycle when out_stall is low; fourteen register stages,
// the eight-step restoring divider for hue and saturation sets the depth
// a stall on the result side holds every stage in place
// reset (rst_n, synchronous): clears all stage valid bits and sets both spaces to RGB
module pixel_color_space_converter
  import pcsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pixel_t                in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data
);

  localparam int NSTG = 14;
  localparam int NDIV = 8;
  localparam int ENC0 = 4;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [2:0]  sector;
    logic [16:0] f;
    logic [16:0] s;
    logic [16:0] l;
  } dec1_t;

  typedef struct packed {
    logic [7:0]         a;
    logic [7:0]         b;
    logic [7:0]         c;
    logic [2:0]         sector;
    logic [16:0]        f;
    logic [16:0]        l;
    logic [16:0]        cc;
    logic signed [43:0] p_r;
    logic signed [43:0] p_gb;
    logic signed [43:0] p_gr;
    logic signed [43:0] p_b;
  } dec2_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [2:0]  sector;
    logic [16:0] cc;
    logic [16:0] m;
    logic [16:0] x;
    logic [7:0]  yr;
    logic [7:0]  yg;
    logic [7:0]  yb;
  } dec3_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [23:0] mag;
    logic        neg;
    logic [23:0] q;
    logic [40:0] rem;
    logic [7:0]  res;
  } chroma_t;

  typedef struct packed {
    logic [2:0][7:0] fixed;
    logic [19:0]     hue_rem;
    logic [10:0]     hue_den;
    logic [7:0]      hue_q;
    logic [15:0]     sat_rem;
    logic [7:0]      sat_den;
    logic [7:0]      sat_q;
    logic [7:0]      ybyte;
    chroma_t         cb;
    chroma_t         cr;
  } enc_t;

  space_t          src_r, tgt_r;
  logic [NSTG-1:0] v_r;
  logic            pipe_en;

  dec1_t   d1_r, d1_nxt;
  dec2_t   d2_r, d2_nxt;
  dec3_t   d3_r, d3_nxt;
  rgb_t    rgb_r, rgb_nxt;
  enc_t    enc_r [0:NDIV];
  enc_t    enc_nxt [0:NDIV];
  result_t out_r, out_nxt;

  logic src_hsl, src_709, tgt_709;
  logic [16:0] cb_den, cr_den;
  logic [23:0] cb_inv, cr_inv;

  assign src_hsl = (src_r == SP_HSL);
  assign src_709 = (src_r == SP_YCC709);
  assign tgt_709 = (tgt_r == SP_YCC709);
  assign cb_den  = tgt_709 ? 17'(CBB_709) : 17'(CBB_601);
  assign cr_den  = tgt_709 ? 17'(CRR_709) : 17'(CRR_601);
  assign cb_inv  = tgt_709 ? 24'(INV_CBB_709) : 24'(INV_CBB_601);
  assign cr_inv  = tgt_709 ? 24'(INV_CRR_709) : 24'(INV_CRR_601);

  function automatic chroma_t chroma_step(input chroma_t c, input int k,
                                          input logic [23:0] inv, input logic [16:0] den);
    chroma_t o;
    logic [47:0] prod;
    logic [24:0] qf;
    logic signed [47:0] v;
    o = c;
    prod = 48'(c.mag) * 48'(inv);
    qf = 25'(c.q) + 25'(c.rem >= 41'(den));
    v = c.neg ? 48'(MID) - 48'(qf) : 48'(MID) + 48'(qf);
    case (k)
      1: o.q = prod[INV_SHIFT+23:INV_SHIFT];
      2: o.rem = {c.mag, {FRAC_BITS{1'b0}}} - 41'(c.q) * 41'(den);
      3: o.res = to_byte(v);
      default: o = c;
    endcase
    return o;
  endfunction

  function automatic enc_t enc_step(input enc_t e, input int k);
    enc_t o;
    logic [2:0] j;
    logic [19:0] hsh;
    logic [15:0] ssh;
    o = e;
    j = 3'(NDIV - k);
    hsh = 20'(e.hue_den) << j;
    ssh = 16'(e.sat_den) << j;
    if (e.hue_rem >= hsh) begin
      o.hue_rem = e.hue_rem - hsh;
      o.hue_q[j] = 1'b1;
    end
    if (e.sat_rem >= ssh) begin
      o.sat_rem = e.sat_rem - ssh;
      o.sat_q[j] = 1'b1;
    end
    o.cb = chroma_step(e.cb, k, cb_inv, cb_den);
    o.cr = chroma_step(e.cr, k, cr_inv, cr_den);
    return o;
  endfunction

  // stage 1: hue sector and byte-to-unit scaling
  logic [2:0]  six_a;
  logic [18:0] hp;
  always_comb begin
    if (in_data.chan_first == 8'd255)      six_a = 3'd6;
    else if (in_data.chan_first >= 8'd213) six_a = 3'd5;
    else if (in_data.chan_first >= 8'd170) six_a = 3'd4;
    else if (in_data.chan_first >= 8'd128) six_a = 3'd3;
    else if (in_data.chan_first >= 8'd85)  six_a = 3'd2;
    else if (in_data.chan_first >= 8'd43)  six_a = 3'd1;
    else                                   six_a = 3'd0;
    hp = 19'(in_data.chan_first) * 19'd1542 + 19'(six_a);
    d1_nxt.a = in_data.chan_first;
    d1_nxt.b = in_data.chan_second;
    d1_nxt.c = in_data.chan_third;
    d1_nxt.sector = hp[FRAC_BITS+2:FRAC_BITS];
    d1_nxt.f = hp[FRAC_BITS:0];
    d1_nxt.s = 17'(in_data.chan_second) * 17'd257 + 17'(in_data.chan_second == 8'hFF);
    d1_nxt.l = 17'(in_data.chan_third) * 17'd257 + 17'(in_data.chan_third == 8'hFF);
  end

  // stage 2: chroma product and ycbcr products
  logic [17:0] two_l, dev1;
  logic [16:0] t1, mop;
  logic [33:0] prod1;
  logic signed [24:0] cbv, crv;
  logic signed [18:0] k_crr, k_cbb, k_gb, k_gr;
  always_comb begin
    two_l = {d1_r.l, 1'b0};
    dev1 = (two_l >= 18'(ONE)) ? two_l - 18'(ONE) : 18'(ONE) - two_l;
    t1 = 17'(18'(ONE) - dev1);
    mop = src_hsl ? t1 : d1_r.l;
    prod1 = 34'(mop) * 34'(d1_r.s);
    cbv = $signed({1'b0, d1_r.b, {FRAC_BITS{1'b0}}}) - 25'(MID);
    crv = $signed({1'b0, d1_r.c, {FRAC_BITS{1'b0}}}) - 25'(MID);
    k_crr = src_709 ? 19'(CRR_709) : 19'(CRR_601);
    k_cbb = src_709 ? 19'(CBB_709) : 19'(CBB_601);
    k_gb = src_709 ? 19'(KGB_709) : 19'(KGB_601);
    k_gr = src_709 ? 19'(KGR_709) : 19'(KGR_601);
    d2_nxt.a = d1_r.a;
    d2_nxt.b = d1_r.b;
    d2_nxt.c = d1_r.c;
    d2_nxt.sector = d1_r.sector;
    d2_nxt.f = d1_r.f;
    d2_nxt.l = d1_r.l;
    d2_nxt.cc = prod1[FRAC_BITS+16:FRAC_BITS];
    d2_nxt.p_r = crv * k_crr;
    d2_nxt.p_gb = cbv * k_gb;
    d2_nxt.p_gr = crv * k_gr;
    d2_nxt.p_b = cbv * k_cbb;
  end

  // stage 3: offset, sector ramp, ycbcr sums
  logic [16:0] dev2, t2;
  logic [33:0] prod2;
  logic signed [47:0] y3;
  always_comb begin
    dev2 = (d2_r.f >= 17'(ONE)) ? d2_r.f - 17'(ONE) : 17'(ONE) - d2_r.f;
    t2 = 17'(ONE) - dev2;
    prod2 = 34'(d2_r.cc) * 34'(t2);
    y3 = $signed(48'({d2_r.a, {FRAC_BITS{1'b0}}}));
    d3_nxt.a = d2_r.a;
    d3_nxt.b = d2_r.b;
    d3_nxt.c = d2_r.c;
    d3_nxt.sector = d2_r.sector;
    d3_nxt.cc = d2_r.cc;
    d3_nxt.m = src_hsl ? d2_r.l - (d2_r.cc >> 1) : d2_r.l - d2_r.cc;
    d3_nxt.x = prod2[FRAC_BITS+16:FRAC_BITS];
    d3_nxt.yr = to_byte(y3 + trunc_fx(48'(d2_r.p_r)));
    d3_nxt.yg = to_byte(y3 - trunc_fx(48'(d2_r.p_gb)) - trunc_fx(48'(d2_r.p_gr)));
    d3_nxt.yb = to_byte(y3 + trunc_fx(48'(d2_r.p_b)));
  end

  // stage 4: rgb select per source space
  logic [7:0] pv, qv, zv;
  rgb_t hsx;
  logic signed [47:0] y4, co4, cg4;
  always_comb begin
    pv = scale255(18'(d3_r.cc) + 18'(d3_r.m));
    qv = scale255(18'(d3_r.x) + 18'(d3_r.m));
    zv = scale255(18'(d3_r.m));
    case (d3_r.sector)
      3'd0: hsx = '{r: pv, g: qv, b: zv};
      3'd1: hsx = '{r: qv, g: pv, b: zv};
      3'd2: hsx = '{r: zv, g: pv, b: qv};
      3'd3: hsx = '{r: zv, g: qv, b: pv};
      3'd4: hsx = '{r: qv, g: zv, b: pv};
      default: hsx = '{r: pv, g: zv, b: qv};
    endcase
    y4 = $signed(48'({d3_r.a, {FRAC_BITS{1'b0}}}));
    co4 = $signed(48'({d3_r.b, {FRAC_BITS{1'b0}}})) - 48'(MID);
    cg4 = $signed(48'({d3_r.c, {FRAC_BITS{1'b0}}})) - 48'(MID);
    case (src_r)
      SP_HSL, SP_HSV: rgb_nxt = hsx;
      SP_YCC601, SP_YCC709: rgb_nxt = '{r: d3_r.yr, g: d3_r.yg, b: d3_r.yb};
      SP_YCOCG: rgb_nxt = '{r: to_byte(y4 + co4 - cg4), g: to_byte(y4 + cg4),
                            b: to_byte(y4 - co4 - cg4)};
      SP_CMY: rgb_nxt = '{r: 8'd255 - d3_r.a, g: 8'd255 - d3_r.b, b: 8'd255 - d3_r.c};
      default: rgb_nxt = '{r: d3_r.a, g: d3_r.b, b: d3_r.c};
    endcase
  end

  // encode prep: extremes, divider operands, luma
  logic [7:0] mx, mn, cc8;
  logic [8:0] sum, sum_inv;
  logic signed [11:0] n;
  logic [16:0] kr_e, kg_e, kb_e;
  logic [23:0] yv;
  logic signed [24:0] xb, xr;
  logic [9:0] sum4, cgs;
  logic [8:0] cos;
  always_comb begin
    mx = rgb_r.r;
    mn = rgb_r.r;
    if (rgb_r.g > mx) mx = rgb_r.g;
    if (rgb_r.b > mx) mx = rgb_r.b;
    if (rgb_r.g < mn) mn = rgb_r.g;
    if (rgb_r.b < mn) mn = rgb_r.b;
    cc8 = mx - mn;
    if (mx == rgb_r.r) begin
      n = $signed(12'(rgb_r.g)) - $signed(12'(rgb_r.b));
      if (n < 0) n = n + $signed(12'(cc8) * 12'd6);
    end else if (mx == rgb_r.g) begin
      n = $signed(12'(cc8) * 12'd2) + $signed(12'(rgb_r.b)) - $signed(12'(rgb_r.r));
    end else begin
      n = $signed(12'(cc8) * 12'd4) + $signed(12'(rgb_r.r)) - $signed(12'(rgb_r.g));
    end
    sum = 9'(mx) + 9'(mn);
    sum_inv = 9'd510 - sum;

    kr_e = tgt_709 ? 17'(KR_709) : 17'(KR_601);
    kg_e = tgt_709 ? 17'(KG_709) : 17'(KG_601);
    kb_e = tgt_709 ? 17'(KB_709) : 17'(KB_601);
    yv = 24'(kr_e) * 24'(rgb_r.r) + 24'(kg_e) * 24'(rgb_r.g) + 24'(kb_e) * 24'(rgb_r.b);
    xb = $signed({1'b0, rgb_r.b, {FRAC_BITS{1'b0}}}) - $signed({1'b0, yv});
    xr = $signed({1'b0, rgb_r.r, {FRAC_BITS{1'b0}}}) - $signed({1'b0, yv});

    sum4 = 10'(rgb_r.r) + 10'(rgb_r.g) + 10'(rgb_r.g) + 10'(rgb_r.b);
    cos = 9'(rgb_r.r) - 9'(rgb_r.b) + 9'd255;
    cgs = 10'(rgb_r.g) + 10'(rgb_r.g) + 10'd510 - 10'(rgb_r.r) - 10'(rgb_r.b);

    enc_nxt[0] = '0;
    enc_nxt[0].hue_rem = (cc8 == 8'd0) ? 20'd0 : 20'(n[10:0]) * 20'd255;
    enc_nxt[0].hue_den = (cc8 == 8'd0) ? 11'd1 : 11'(cc8) * 11'd6;
    enc_nxt[0].sat_rem = 16'(cc8) * 16'd255;
    if (tgt_r == SP_HSV) begin
      enc_nxt[0].sat_den = (mx == 8'd0) ? 8'd1 : mx;
    end else begin
      enc_nxt[0].sat_den = (sum < sum_inv) ? sum[7:0] : sum_inv[7:0];
      if (cc8 == 8'd0) enc_nxt[0].sat_den = 8'd1;
    end
    enc_nxt[0].ybyte = yv[FRAC_BITS+7:FRAC_BITS];
    enc_nxt[0].cb.neg = xb[24];
    enc_nxt[0].cb.mag = xb[24] ? 24'(-xb) : xb[23:0];
    enc_nxt[0].cr.neg = xr[24];
    enc_nxt[0].cr.mag = xr[24] ? 24'(-xr) : xr[23:0];
    case (tgt_r)
      SP_HSL: enc_nxt[0].fixed = {8'd0, 8'd0, sum[8:1]};
      SP_HSV: enc_nxt[0].fixed = {8'd0, 8'd0, mx};
      SP_YCOCG: enc_nxt[0].fixed = {sum4[9:2], cos[8:1], cgs[9:2]};
      SP_CMY: enc_nxt[0].fixed = {8'd255 - rgb_r.r, 8'd255 - rgb_r.g, 8'd255 - rgb_r.b};
      default: enc_nxt[0].fixed = {rgb_r.r, rgb_r.g, rgb_r.b};
    endcase

    // divider steps
    for (int k = 1; k <= NDIV; k++) begin
      enc_nxt[k] = enc_step(enc_r[k-1], k);
    end
  end

  always_comb begin
    case (tgt_r)
      SP_HSL, SP_HSV: out_nxt = '{res_first: enc_r[NDIV].hue_q,
                                  res_second: enc_r[NDIV].sat_q,
                                  res_third: enc_r[NDIV].fixed[0]};
      SP_YCC601, SP_YCC709: out_nxt = '{res_first: enc_r[NDIV].ybyte,
                                        res_second: enc_r[NDIV].cb.res,
                                        res_third: enc_r[NDIV].cr.res};
      default: out_nxt = '{res_first: enc_r[NDIV].fixed[2],
                           res_second: enc_r[NDIV].fixed[1],
                           res_third: enc_r[NDIV].fixed[0]};
    endcase
  end

  assign pipe_en   = !(v_r[NSTG-1] && out_stall);
  assign in_stall  = !pipe_en;
  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SP_RGB;
      tgt_r <= SP_RGB;
      v_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE: src_r <= space_t'(cfg_wdata);
          CFG_TARGET: tgt_r <= space_t'(cfg_wdata);
          default: ;
        endcase
      end
      if (pipe_en) v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      d3_r <= d3_nxt;
      rgb_r <= rgb_nxt;
      for (int k = 0; k <= NDIV; k++) begin
        enc_r[k] <= enc_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  // a held pipeline keeps every valid bit
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(v_r)) else $error("valid bits moved during stall");

  // divider quotients fit in one byte
  a_hue_fit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ENC0] |-> (enc_r[0].hue_rem < (20'(enc_r[0].hue_den) << 8)))
    else $error("hue quotient overflow");

  a_sat_fit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ENC0] |-> (enc_r[0].sat_rem < (24'(enc_r[0].sat_den) << 8)))
    else $error("saturation quotient overflow");

  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ENC0] |-> (enc_r[0].hue_den != 11'd0 && enc_r[0].sat_den != 8'd0))
    else $error("zero divisor");

  // reciprocal estimate is off by at most one
  a_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ENC0+2] |-> (enc_r[2].cb.rem < {24'd0, cb_den, 1'b0} &&
                     enc_r[2].cr.rem < {24'd0, cr_den, 1'b0}))
    else $error("chroma quotient correction out of range");

endmodule

FILE: sim/pixel_color_space_converter_test.sv
module pixel_color_space_converter_test;
  import pcsc_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_stall_q;
  pixel_t in_data;
  logic out_valid;
  logic out_stall;
  result_t out_data;

  pixel_t pending_pixels[$];
  result_t expected_pixels[$];
  logic [2:0] src_sp;
  logic [2:0] dst_sp;
  int errors;
  int send_gap;
  int recv_gap;
  bit idle_on;

  pixel_color_space_converter i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp_byte(longint v);
    if (v < 0) v = 0;
    if (v > FULL) v = FULL;
    return v / ONE;
  endfunction

  function automatic longint fx_mul(longint x, longint k);
    return x * k / ONE;
  endfunction

  function automatic longint fx_abs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void pick_weights(logic [2:0] sp, output longint kr, output longint kg,
                                       output longint kb);
    if (sp == SP_YCC709) begin
      kr = (2126 * ONE + 5000) / 10000;
      kg = (7152 * ONE + 5000) / 10000;
      kb = (722 * ONE + 5000) / 10000;
    end else begin
      kr = (299 * ONE + 500) / 1000;
      kg = (587 * ONE + 500) / 1000;
      kb = (114 * ONE + 500) / 1000;
    end
  endfunction

  function automatic result_t convert_pixel(pixel_t px);
    longint a, b, c, r, g, bl, kr, kg, kb;
    longint hp, sector, f, s, l, cc, m, x, p, q, z, crr, cbb, y;
    longint mx, mn, n, hue, sat, sum;
    longint o0, o1, o2;
    result_t res;
    a = longint'(px.chan_first);
    b = longint'(px.chan_second);
    c = longint'(px.chan_third);
    if (src_sp == SP_HSL || src_sp == SP_HSV) begin
      hp = a * 6 * ONE / 255;
      sector = hp / ONE;
      f = hp % (2 * ONE);
      s = b * ONE / 255;
      l = c * ONE / 255;
      if (src_sp == SP_HSL) begin
        cc = fx_mul(ONE - fx_abs(2 * l - ONE), s);
        m = l - cc / 2;
      end else begin
        cc = fx_mul(s, l);
        m = l - cc;
      end
      x = fx_mul(cc, ONE - fx_abs(f - ONE));
      p = clamp_byte(255 * (cc + m));
      q = clamp_byte(255 * (x + m));
      z = clamp_byte(255 * m);
      if (sector > 5) sector = 5;
      case (sector)
        0: begin r = p; g = q; bl = z; end
        1: begin r = q; g = p; bl = z; end
        2: begin r = z; g = p; bl = q; end
        3: begin r = z; g = q; bl = p; end
        4: begin r = q; g = z; bl = p; end
        default: begin r = p; g = z; bl = q; end
      endcase
    end else if (src_sp == SP_YCC601 || src_sp == SP_YCC709) begin
      pick_weights(src_sp, kr, kg, kb);
      y = a * ONE;
      crr = 2 * ONE - 2 * kr;
      cbb = 2 * ONE - 2 * kb;
      r = clamp_byte(y + fx_mul(c * ONE - MID, crr));
      g = clamp_byte(y - fx_mul(b * ONE - MID, kb * cbb / kg)
                     - fx_mul(c * ONE - MID, kr * crr / kg));
      bl = clamp_byte(y + fx_mul(b * ONE - MID, cbb));
    end else if (src_sp == SP_YCOCG) begin
      y = a * ONE;
      r = clamp_byte(y + (b * ONE - MID) - (c * ONE - MID));
      g = clamp_byte(y + (c * ONE - MID));
      bl = clamp_byte(y - (b * ONE - MID) - (c * ONE - MID));
    end else if (src_sp == SP_CMY) begin
      r = 255 - a; g = 255 - b; bl = 255 - c;
    end else begin
      r = a; g = b; bl = c;
    end

    if (dst_sp == SP_HSL || dst_sp == SP_HSV) begin
      mx = r; mn = r; hue = 0; sat = 0;
      if (g > mx) mx = g;
      if (bl > mx) mx = bl;
      if (g < mn) mn = g;
      if (bl < mn) mn = bl;
      cc = mx - mn;
      if (cc != 0) begin
        if (mx == r) begin
          n = g - bl;
          if (n < 0) n += 6 * cc;
        end else if (mx == g) n = 2 * cc + (bl - r);
        else n = 4 * cc + (r - g);
        hue = 255 * n / (6 * cc);
      end
      if (dst_sp == SP_HSV) begin
        if (mx != 0) sat = 255 * cc / mx;
        o2 = mx;
      end else begin
        sum = mx + mn;
        if (sum != 0 && sum != 510)
          sat = 255 * cc / (sum < 510 - sum ? sum : 510 - sum);
        o2 = sum / 2;
      end
      o0 = hue;
      o1 = sat;
    end else if (dst_sp == SP_YCC601 || dst_sp == SP_YCC709) begin
      pick_weights(dst_sp, kr, kg, kb);
      y = kr * r + kg * g + kb * bl;
      o0 = clamp_byte(y);
      o1 = clamp_byte((bl * ONE - y) * ONE / (2 * ONE - 2 * kb) + MID);
      o2 = clamp_byte((r * ONE - y) * ONE / (2 * ONE - 2 * kr) + MID);
    end else if (dst_sp == SP_YCOCG) begin
      o0 = clamp_byte((r + 2 * g + bl) * ONE / 4);
      o1 = clamp_byte((r - bl) * ONE / 2 + MID);
      o2 = clamp_byte((2 * g - r - bl) * ONE / 4 + MID);
    end else if (dst_sp == SP_CMY) begin
      o0 = 255 - r; o1 = 255 - g; o2 = 255 - bl;
    end else begin
      o0 = r; o1 = g; o2 = bl;
    end
    res.res_first = o0[7:0];
    res.res_second = o1[7:0];
    res.res_third = o2[7:0];
    return res;
  endfunction

  function automatic bit gap_start();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(0, 12);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall_q) begin
      // previous transaction taken at the last rising edge
      if (pending_pixels.size() > 0 && send_gap == 0 && !gap_start()) begin
        in_data <= pending_pixels.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_pixels.size() > 0 && !gap_start()) begin
        in_data <= pending_pixels.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall) expected_pixels.push_back(convert_pixel(in_data));
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        errors++;
      end else begin
        result_t want;
        want = expected_pixels.pop_front();
        if (out_data.res_first !== want.res_first) begin
          $error("res_first expected %0d actual %0d", want.res_first, out_data.res_first);
          errors++;
        end
        if (out_data.res_second !== want.res_second) begin
          $error("res_second expected %0d actual %0d", want.res_second, out_data.res_second);
          errors++;
        end
        if (out_data.res_third !== want.res_third) begin
          $error("res_third expected %0d actual %0d", want.res_third, out_data.res_third);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      if (recv_gap == 1) out_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(1, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_space(logic [CFG_IDX_W-1:0] idx, space_t sp);
    @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= sp;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE) src_sp = sp;
    else dst_sp = sp;
  endtask

  task automatic queue_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pixel_t px;
    px.chan_first = a;
    px.chan_second = b;
    px.chan_third = c;
    pending_pixels.push_back(px);
  endtask

  task automatic run_phase(space_t src, space_t dst, int count);
    set_space(CFG_SOURCE, src);
    set_space(CFG_TARGET, dst);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 5))
        0: queue_pixel(8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 1) * 255),
                       8'($urandom_range(0, 1) * 255));
        1: begin
          logic [7:0] v;
          v = 8'($urandom);
          queue_pixel(v, v, v);
        end
        default: queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    space_t sp_list[7];
    errors = 0;
    idle_on = 1'b1;
    send_gap = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    in_stall_q = 1'b0;
    src_sp = SP_RGB;
    dst_sp = SP_RGB;
    sp_list = '{SP_RGB, SP_HSL, SP_HSV, SP_YCC601, SP_YCC709, SP_YCOCG, SP_CMY};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, grays, hue ends, under reset spaces
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hFF, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hFF, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hFF);
    queue_pixel(8'h80, 8'h80, 8'h80);
    queue_pixel(8'hFF, 8'hFF, 8'h80);
    queue_pixel(8'hAA, 8'h55, 8'h01);
    drain();
    run_phase(SP_HSL, SP_RGB, 6);
    run_phase(SP_RGB, SP_HSV, 6);

    for (int s = 0; s < 7; s++)
      for (int d = 0; d < 7; d++)
        run_phase(sp_list[s], sp_list[d], 9);

    // unused code 7 behaves as pass-through
    @(negedge clk);
    cfg_index <= CFG_SOURCE;
    cfg_wdata <= 3'd7;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_index <= CFG_TARGET;
    @(negedge clk);
    cfg_we <= 1'b0;
    src_sp = 3'd7;
    dst_sp = 3'd7;
    for (int k = 0; k < 8; k++) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    drain();

    idle_on = 1'b0;
    run_phase(SP_YCC709, SP_HSL, 40);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: pixel_color_space_converter.f
hw/rtl/pcsc_pkg.sv
hw/rtl/pixel_color_space_converter.sv
sim/pixel_color_space_converter_test.sv
